// ===== sv/assert_macros.svh =====
// assertion macros for the rtl files, included by the edge filter unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== sv/kuf_pkg.sv =====
// shared constants for the kruskal union-find edge filter
`default_nettype none

package kuf_pkg;

	localparam int NODE_COUNT_DEF  = 1024;
	localparam int WEIGHT_BITS_DEF = 32;
	localparam int NODE_BITS       = 10;
	localparam int RANK_BITS       = 4;
	localparam logic [RANK_BITS-1:0] RANK_MAX = '1;

endpackage

`default_nettype wire

// ===== sv/kruskal_union_find_edge_filter_unit.sv =====
// streaming kruskal edge filter: order check, up to two root finds with path compression, union by rank
// each root find walks the parent links to the root and then compresses the path, and a union
// writes one or two entries; a self-loop does a single root find, a rejected item none
// one item in work at a time, the next accepted the cycle after its result is registered, as
// the node store has one write and one registered read port; configuration taken throughout
// after reset a clearing pass makes every node its own root with rank zero, no item before
`default_nettype none

`include "assert_macros.svh"

module kruskal_union_find_edge_filter_unit #(
	parameter int NODE_COUNT  = kuf_pkg::NODE_COUNT_DEF,
	parameter int WEIGHT_BITS = kuf_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_wdata,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [kuf_pkg::NODE_BITS-1:0]       node_a,
	input  wire logic [kuf_pkg::NODE_BITS-1:0]       node_b,
	input  wire logic signed [WEIGHT_BITS-1:0]       edge_weight,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     edge_taken,
	output logic                                     self_loop,
	output logic                                     order_error,
	output logic      [kuf_pkg::NODE_BITS-1:0]       merged_root
);

	localparam int NW = $clog2(NODE_COUNT);
	localparam int RB = kuf_pkg::RANK_BITS;
	localparam int NB = kuf_pkg::NODE_BITS;
	localparam int EW = RB + NW;
	localparam logic [NW-1:0] LAST_NODE = NW'(NODE_COUNT - 1);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_FSTART = 4'd2;
	localparam logic [3:0] ST_FWALK  = 4'd3;
	localparam logic [3:0] ST_CWALK  = 4'd4;
	localparam logic [3:0] ST_FEND   = 4'd5;
	localparam logic [3:0] ST_UNION1 = 4'd6;
	localparam logic [3:0] ST_UNION2 = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	// control state
	logic [3:0]    state_q;
	logic [NW-1:0] clr_q;
	logic          mode_q;
	logic          err_q;
	logic          have_q;
	logic          out_valid_q;
	logic          which_q;
	logic          loop_q;

	// payload
	logic [NW-1:0]                 a_q, b_q, cur_q, root_q, ra_q, res_root_q;
	logic [RB-1:0]                 rank_q, rka_q;
	logic signed [WEIGHT_BITS-1:0] w_q, last_q;
	logic                          res_taken_q, res_loop_q;
	logic                          edge_taken_q, self_loop_q, order_error_q;
	logic [NB-1:0]                 merged_root_q;

	// node store port
	logic          mem_we, mem_re;
	logic [NW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;
	logic [NW-1:0] rd_par;
	logic [RB-1:0] rd_rank;

	logic          accept;
	logic          a_ok, b_ok, is_loop, viol, err_n, go_find;
	logic [NW-1:0] start_n;

	kuf_store #(
		.DEPTH(NODE_COUNT),
		.AW   (NW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rd_par  = mem_rdata[NW-1:0];
	assign rd_rank = mem_rdata[EW-1:NW];
	assign start_n = which_q ? b_q : a_q;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign a_ok    = 32'(node_a) < 32'(NODE_COUNT);
	assign b_ok    = 32'(node_b) < 32'(NODE_COUNT);
	assign is_loop = (node_a == node_b);
	// equal weights are in order in both modes
	assign viol    = !err_q && have_q &&
		(mode_q ? (edge_weight > last_q) : (edge_weight < last_q));
	assign err_n   = err_q || viol;
	assign go_find = !err_n && a_ok && (is_loop || b_ok);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {RB'(0), clr_q};
			end
			ST_FSTART: begin
				mem_re    = 1'b1;
				mem_raddr = start_n;
			end
			ST_FWALK: begin
				if (rd_par != cur_q) begin
					mem_re    = 1'b1;
					mem_raddr = rd_par;
				end else if (start_n != cur_q) begin
					// root found, go back to the start for compression
					mem_re    = 1'b1;
					mem_raddr = start_n;
				end
			end
			ST_CWALK: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q;
				mem_wdata = {rd_rank, root_q};
				if (rd_par != root_q) begin
					mem_re    = 1'b1;
					mem_raddr = rd_par;
				end
			end
			ST_UNION1: begin
				mem_we = 1'b1;
				if (rka_q < rank_q) begin
					mem_waddr = ra_q;
					mem_wdata = {rka_q, root_q};
				end else begin
					mem_waddr = root_q;
					mem_wdata = {rank_q, ra_q};
				end
			end
			ST_UNION2: begin
				mem_we    = 1'b1;
				mem_waddr = ra_q;
				mem_wdata = {rka_q + RB'(1), ra_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			mode_q      <= 1'b0;
			err_q       <= 1'b0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
			which_q     <= 1'b0;
			loop_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == LAST_NODE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						err_q   <= err_n;
						which_q <= 1'b0;
						loop_q  <= is_loop;
						state_q <= go_find ? ST_FSTART : ST_DONE;
					end
				end
				ST_FSTART: begin
					state_q <= ST_FWALK;
				end
				ST_FWALK: begin
					if (rd_par == cur_q) begin
						state_q <= (start_n == cur_q) ? ST_FEND : ST_CWALK;
					end
				end
				ST_CWALK: begin
					if (rd_par == root_q) begin
						state_q <= ST_FEND;
					end
				end
				ST_FEND: begin
					if (!which_q) begin
						if (loop_q) begin
							state_q <= ST_DONE;
						end else begin
							which_q <= 1'b1;
							state_q <= ST_FSTART;
						end
					end else begin
						have_q  <= 1'b1;
						state_q <= (ra_q == root_q) ? ST_DONE : ST_UNION1;
					end
				end
				ST_UNION1: begin
					if (rka_q == rank_q && rka_q != kuf_pkg::RANK_MAX) begin
						state_q <= ST_UNION2;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_UNION2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					a_q         <= NW'(node_a);
					b_q         <= NW'(node_b);
					w_q         <= edge_weight;
					res_taken_q <= 1'b0;
					res_loop_q  <= !err_n && is_loop;
					res_root_q  <= '0;
				end
			end
			ST_FSTART: begin
				cur_q <= start_n;
			end
			ST_FWALK: begin
				if (rd_par != cur_q) begin
					cur_q <= rd_par;
				end else begin
					root_q <= cur_q;
					rank_q <= rd_rank;
					cur_q  <= start_n;
				end
			end
			ST_CWALK: begin
				cur_q <= rd_par;
			end
			ST_FEND: begin
				if (!which_q) begin
					ra_q       <= root_q;
					rka_q      <= rank_q;
					res_root_q <= root_q;
				end else begin
					last_q     <= w_q;
					res_root_q <= ra_q;
				end
			end
			ST_UNION1: begin
				res_taken_q <= 1'b1;
				res_root_q  <= (rka_q < rank_q) ? root_q : ra_q;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					edge_taken_q  <= res_taken_q;
					self_loop_q   <= res_loop_q;
					order_error_q <= err_q;
					merged_root_q <= NB'(res_root_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign edge_taken  = edge_taken_q;
	assign self_loop   = self_loop_q;
	assign order_error = order_error_q;
	assign merged_root = merged_root_q;

	`ASSERT_CLK(a_err_sticky, clk, arst_n, err_q |=> err_q)
	`ASSERT_NEVER(a_rw_same_entry, clk, arst_n,
		mem_we && mem_re && (mem_waddr == mem_raddr))
	`ASSERT_NEVER(a_taken_and_loop, clk, arst_n, out_valid_q && edge_taken_q && self_loop_q)
	`ASSERT_CLK(a_err_rejects, clk, arst_n,
		(out_valid_q && order_error_q) |-> (!edge_taken_q && merged_root_q == '0))
	`ASSERT_CLK(a_last_only_clean, clk, arst_n, $rose(have_q) |-> !err_q)

endmodule

`default_nettype wire

// ===== sv/kuf_store.sv =====
// union-find node store: rank and parent per node, one write and one registered read port
`default_nettype none

module kuf_store #(
	parameter int DEPTH = kuf_pkg::NODE_COUNT_DEF,
	parameter int AW    = $clog2(kuf_pkg::NODE_COUNT_DEF)
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [AW-1:0]                    waddr,
	input  wire logic [kuf_pkg::RANK_BITS+AW-1:0] wdata,
	input  wire logic                             re,
	input  wire logic [AW-1:0]                    raddr,
	output logic      [kuf_pkg::RANK_BITS+AW-1:0] rdata
);

	logic [kuf_pkg::RANK_BITS+AW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== verif/kruskal_union_find_edge_filter_unit_tb.sv =====
// testbench for the kruskal union-find edge filter: sorted and out-of-order streams against a local union-find
`timescale 1ns / 100ps

module kruskal_union_find_edge_filter_unit_tb;

	localparam int NODE_COUNT  = kuf_pkg::NODE_COUNT_DEF;
	localparam int NODE_BITS   = kuf_pkg::NODE_BITS;
	localparam int WEIGHT_BITS = kuf_pkg::WEIGHT_BITS_DEF;
	localparam longint W_MAX   = 64'sd2147483647;
	localparam longint W_MIN   = -64'sd2147483648;
	localparam int HOLD_CYCLES = 300;

	localparam bit MODE_MINIMIZE = 1'b0;
	localparam bit MODE_MAXIMIZE = 1'b1;

	typedef struct packed {
		logic                 taken;
		logic                 loop;
		logic                 err;
		logic [NODE_BITS-1:0] root;
	} edge_verdict_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic                          cfg_wdata;
	logic                          in_valid;
	logic                          in_ready;
	logic [NODE_BITS-1:0]          node_a;
	logic [NODE_BITS-1:0]          node_b;
	logic signed [WEIGHT_BITS-1:0] edge_weight;
	logic                          out_valid;
	logic                          out_ready;
	logic                          edge_taken;
	logic                          self_loop;
	logic                          order_error;
	logic [NODE_BITS-1:0]          merged_root;

	kruskal_union_find_edge_filter_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.node_a     (node_a),
		.node_b     (node_b),
		.edge_weight(edge_weight),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.edge_taken (edge_taken),
		.self_loop  (self_loop),
		.order_error(order_error),
		.merged_root(merged_root)
	);

	always #4 clk = ~clk;

	// local copy of the forest and the order state
	logic [NODE_BITS-1:0]         uf_parent [NODE_COUNT];
	logic [kuf_pkg::RANK_BITS-1:0] uf_rank  [NODE_COUNT];
	logic signed [WEIGHT_BITS-1:0] uf_last;
	bit                            uf_have_last;
	bit                            uf_error;
	bit                            uf_maximize;

	edge_verdict_t verdicts_due[$];

	bit steady;
	bit hold_request;
	int hold_spells;
	int failures;
	int n_edges, n_taken, n_joined, n_loops, n_rejected;

	function automatic logic [NODE_BITS-1:0] root_with_compress(logic [NODE_BITS-1:0] n);
		logic [NODE_BITS-1:0] r;
		logic [NODE_BITS-1:0] p;
		r = n;
		while (uf_parent[r] != r)
			r = uf_parent[r];
		while (n != r) begin
			p = uf_parent[n];
			uf_parent[n] = r;
			n = p;
		end
		return r;
	endfunction

	function automatic edge_verdict_t kruskal_verdict(logic [NODE_BITS-1:0] a,
			logic [NODE_BITS-1:0] b, logic signed [WEIGHT_BITS-1:0] w);
		edge_verdict_t v;
		logic [NODE_BITS-1:0] ra;
		logic [NODE_BITS-1:0] rb;
		v = '0;
		if (!uf_error && uf_have_last) begin
			if (uf_maximize ? (w > uf_last) : (w < uf_last))
				uf_error = 1'b1;
		end
		if (!uf_error) begin
			if (a == b) begin
				v.loop = 1'b1;
				v.root = root_with_compress(a);
			end else begin
				ra = root_with_compress(a);
				rb = root_with_compress(b);
				if (ra != rb) begin
					v.taken = 1'b1;
					if (uf_rank[ra] < uf_rank[rb]) begin
						uf_parent[ra] = rb;
						v.root = rb;
					end else begin
						uf_parent[rb] = ra;
						if (uf_rank[ra] == uf_rank[rb] && uf_rank[ra] != kuf_pkg::RANK_MAX)
							uf_rank[ra] = uf_rank[ra] + 1'b1;
						v.root = ra;
					end
				end else begin
					v.root = ra;
				end
				uf_last = w;
				uf_have_last = 1'b1;
			end
		end
		v.err = uf_error;
		return v;
	endfunction

	// next weight that keeps the stream sorted; a peek may run ahead for a self-loop
	function automatic logic signed [WEIGHT_BITS-1:0] sorted_weight(bit down, int left, bit peek);
		longint cur, room, span, stepv;
		cur = uf_have_last ? longint'(uf_last) : 64'sd0;
		room = down ? cur - W_MIN : W_MAX - cur;
		span = peek ? room : (2 * room) / ((left > 0) ? left : 1);
		if (span > 64'sd4294967295)
			span = 64'sd4294967295;
		stepv = ($urandom_range(0, 3) == 0) ? 64'sd0 : longint'($urandom_range(0, 32'(span)));
		return WEIGHT_BITS'(down ? cur - stepv : cur + stepv);
	endfunction

	task automatic send_edge(input logic [NODE_BITS-1:0] a, input logic [NODE_BITS-1:0] b,
			input logic signed [WEIGHT_BITS-1:0] w);
		edge_verdict_t v;
		bit hit;
		while (!steady && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		node_a      <= a;
		node_b      <= b;
		edge_weight <= w;
		do begin
			@(negedge clk);
			hit = in_ready;
			@(posedge clk);
		end while (!hit);
		v = kruskal_verdict(a, b, w);
		verdicts_due.push_back(v);
		n_edges++;
		if (v.err)
			n_rejected++;
		else if (v.loop)
			n_loops++;
		else if (v.taken)
			n_taken++;
		else
			n_joined++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_mode(input bit m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		uf_maximize = m;
	endtask

	task automatic check_verdict(input edge_verdict_t got);
		edge_verdict_t want;
		if (verdicts_due.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected result: taken=%0d loop=%0d err=%0d root=%0d",
					got.taken, got.loop, got.err, got.root);
			return;
		end
		want = verdicts_due.pop_front();
		if (got.taken !== want.taken || got.loop !== want.loop || got.err !== want.err
				|| got.root !== want.root) begin
			failures++;
			if (failures <= 10)
				$display("mismatch: expected taken=%0d loop=%0d err=%0d root=%0d,",
					want.taken, want.loop, want.err, want.root,
					" got taken=%0d loop=%0d err=%0d root=%0d",
					got.taken, got.loop, got.err, got.root);
		end
	endtask

	// random sorted stream: mostly local pairs and full-range pairs, some self-loops
	task automatic run_sorted_edges(input int count, input bit down, input int hold_at);
		int i, pick;
		logic [NODE_BITS-1:0] a, b, window_base;
		logic signed [WEIGHT_BITS-1:0] w;
		window_base = NODE_BITS'($urandom);
		for (i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_request = 1'b1;
			if (i % 40 == 0)
				window_base = NODE_BITS'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				a = NODE_BITS'($urandom);
				b = a;
				w = sorted_weight(down, count - i, 1'b1);
			end else if (pick < 50) begin
				a = window_base + NODE_BITS'($urandom_range(0, 31));
				b = window_base + NODE_BITS'($urandom_range(0, 31));
				w = sorted_weight(down, count - i, 1'b0);
			end else begin
				a = NODE_BITS'($urandom);
				b = NODE_BITS'($urandom);
				w = sorted_weight(down, count - i, 1'b0);
			end
			send_edge(a, b, w);
		end
	endtask

	task automatic test_minimize_directed();
		// a self-loop before any weight leaves the order check disarmed
		send_edge(10'd5, 10'd5, 32'sh7FFF_FFFF);
		send_edge(10'd0, 10'd1023, 32'sh8000_0000);
		send_edge(10'd1023, 10'd0, 32'sh8000_0000);
		send_edge(10'd1, 10'd2, 32'sh8000_0001);
		send_edge(10'd2, 10'd1, 32'sh8000_0001);
		send_edge(10'd1023, 10'd2, -32'sd1000);
		send_edge(10'd3, 10'd1023, 32'sd0);
		send_edge(10'd1023, 10'd4, 32'sd0);
		send_edge(10'd2, 10'd2, 32'sd1000);
		send_edge(10'd1023, 10'd1023, 32'sh4000_0000);
		// lower than both self-loop weights, still in order
		send_edge(10'd6, 10'd7, 32'sd100);
		send_edge(10'd8, 10'd9, 32'sd100);
		send_edge(10'd6, 10'd8, 32'sd101);
		send_edge(10'd9, 10'd1022, 32'sd101);
		drain_results();
	endtask

	task automatic test_minimize_random();
		steady = 1'b1;
		run_sorted_edges(130, 1'b0, -1);
		steady = 1'b0;
		run_sorted_edges(250, 1'b0, -1);
		drain_results();
	endtask

	task automatic test_maximize_directed();
		logic signed [WEIGHT_BITS-1:0] top;
		set_mode(MODE_MAXIMIZE);
		top = uf_last;
		send_edge(10'd20, 10'd21, top);
		send_edge(10'd21, 10'd20, top);
		send_edge(10'd22, 10'd22, top - 32'sd10000);
		send_edge(10'd23, 10'd24, top - 32'sd5);
		send_edge(10'd24, 10'd20, top - 32'sd5);
		drain_results();
	endtask

	task automatic test_maximize_random_with_hold_off();
		run_sorted_edges(380, 1'b1, 60);
		send_edge(NODE_BITS'($urandom), NODE_BITS'($urandom), 32'sh8000_0000);
		drain_results();
	endtask

	task automatic test_minimize_to_extremes();
		set_mode(MODE_MINIMIZE);
		run_sorted_edges(360, 1'b0, -1);
		send_edge(NODE_BITS'($urandom), NODE_BITS'($urandom), 32'sh7FFF_FFFF);
		drain_results();
	endtask

	task automatic test_order_violation();
		int i;
		logic [NODE_BITS-1:0] a;
		send_edge(10'd30, 10'd31, 32'sh7FFF_FFFE);
		for (i = 0; i < 12; i++) begin
			a = NODE_BITS'($urandom);
			send_edge(a, ($urandom_range(0, 3) == 0) ? a : NODE_BITS'($urandom), $urandom);
		end
		drain_results();
		// error stays up whatever the mode
		set_mode(MODE_MAXIMIZE);
		for (i = 0; i < 6; i++) begin
			a = NODE_BITS'($urandom);
			send_edge(a, ($urandom_range(0, 2) == 0) ? a : NODE_BITS'($urandom), $urandom);
		end
		drain_results();
	endtask

	initial begin : result_sink
		bit fire;
		edge_verdict_t got;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			fire = out_valid && out_ready;
			got = {edge_taken, self_loop, order_error, merged_root};
			@(posedge clk);
			if (fire)
				check_verdict(got);
			if (hold_request) begin
				// long hold-off so the block fills up and stalls its input
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				hold_spells++;
			end else begin
				out_ready <= steady || ($urandom_range(0, 99) >= 14);
			end
		end
	end

	initial begin
		int i;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= 1'b0;
		in_valid    <= 1'b0;
		node_a      <= '0;
		node_b      <= '0;
		edge_weight <= '0;
		for (i = 0; i < NODE_COUNT; i++) begin
			uf_parent[i] = NODE_BITS'(i);
			uf_rank[i]   = '0;
		end
		uf_last      = '0;
		uf_have_last = 1'b0;
		uf_error     = 1'b0;
		uf_maximize  = MODE_MINIMIZE;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_minimize_directed();
		test_minimize_random();
		test_maximize_directed();
		test_maximize_random_with_hold_off();
		test_minimize_to_extremes();
		test_order_violation();

		drain_results();
		repeat (60) @(posedge clk);
		$display("covered %0d edges: %0d joined two trees, %0d already joined,",
			n_edges, n_taken, n_joined,
			" %0d self-loops, %0d rejected", n_loops, n_rejected);
		$display("both weight orders swept end to end, %0d long output hold-off(s)", hold_spells);
		if (failures == 0 && verdicts_due.size() == 0)
			$display("kruskal_union_find_edge_filter_unit_tb OK");
		else
			$display("kruskal_union_find_edge_filter_unit_tb NOT OK");
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout");
		$display("kruskal_union_find_edge_filter_unit_tb NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/kuf_pkg.sv
sv/kuf_store.sv
sv/kruskal_union_find_edge_filter_unit.sv
verif/kruskal_union_find_edge_filter_unit_tb.sv
